// File: rtl/hbp_pkg.sv
// types, constants and the token-set function for the header block parser
// used by the result interface, the step logic, the top level and the checker
package hbp_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_NAME_START  = 4'd0,
    PH_NAME        = 4'd1,
    PH_COLON       = 4'd2,
    PH_VALUE_START = 4'd3,
    PH_VALUE       = 4'd4,
    PH_LF_VALUE    = 4'd5,
    PH_NEXT        = 4'd6,
    PH_LF_END      = 4'd7,
    PH_DONE        = 4'd8,
    PH_ERROR       = 4'd9
  } phase_t;

  // result kinds
  typedef enum logic [2:0] {
    K_NAME  = 3'd0,
    K_VALUE = 3'd1,
    K_HDR   = 3'd2,
    K_DONE  = 3'd3,
    K_ERR   = 3'd4
  } kind_t;

  // error codes, zero also for non-error results
  typedef enum logic [2:0] {
    ERR_NAME_START = 3'd0,
    ERR_NAME_CHAR  = 3'd1,
    ERR_COLON      = 3'd2,
    ERR_LF_VALUE   = 3'd3,
    ERR_NEXT_HDR   = 3'd4,
    ERR_FINAL_LF   = 3'd5
  } err_t;

  // special characters
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_HT    = 8'd9;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_SEMI  = 8'd59;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_ALLOW_SEMI = 1'b0;

  // one result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    err_t       error_code;
    logic       last;
  } result_t;

  // what the step logic sees of one byte and the parser state
  typedef struct packed {
    phase_t     phase;
    logic       hdr_open;
    logic [7:0] data_byte;
    logic       block_start;
    logic       allow_semi;
  } step_in_t;

  // what the step logic gives back
  typedef struct packed {
    phase_t     phase_next;
    logic       hdr_open_next;
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_out_t;

  // rfc token set: alpha, digit and the listed symbols
  function automatic logic is_token(input logic [7:0] b);
    logic t;
    t = 1'b0;
    if (b >= 8'd48 && b <= 8'd57) t = 1'b1;
    if (b >= 8'd65 && b <= 8'd90) t = 1'b1;
    if (b >= 8'd97 && b <= 8'd122) t = 1'b1;
    case (b)
      8'd33, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39,
      8'd42, 8'd43, 8'd45, 8'd46, 8'd94, 8'd95,
      8'd96, 8'd124, 8'd126: t = 1'b1;
      default: ;
    endcase
    return t;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_HT);
  endfunction

endpackage

// File: rtl/hbp_in_if.sv
// input channel of the header block parser: one raw byte per word
// depends on nothing
interface hbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

// File: rtl/hbp_out_if.sv
// result channel of the header block parser: one tagged result per word
// depends on hbp_pkg
interface hbp_out_if;
  logic              valid;
  logic              ready;
  hbp_pkg::kind_t    kind;
  logic [7:0]        out_byte;
  hbp_pkg::err_t     error_code;
  logic              last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input last, output ready);
endinterface

// File: rtl/http_header_block_parser.sv
// top level of the http/1.1 header block parser
// depends on hbp_pkg, hbp_in_if, hbp_out_if and hbp_step
//
// Bytes of a header block enter one word at a time on inp and are parsed in a
// single pass between an input register and a two-entry result buffer; tagged
// results (name byte, value byte, header complete, block done, error) leave on
// outp, one per word, with last set on the final result of each byte. A byte
// can be taken every cycle while outp is ready: most bytes give zero or one
// result, and a byte that opens the next header gives two, which holds the
// input while the second result drains through the single output port. An
// accepted byte is registered in the input register, its first result in the
// result buffer. The allow_semicolon_in_name register sits at byte address 0
// of the APB port and resets to 1; write it only while the parser is idle.
module http_header_block_parser (
  input  logic                            clk,
  input  logic                            rst,
  hbp_in_if.sink                          inp,
  hbp_out_if.source                       outp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hbp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [hbp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hbp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic               allow_semi;
  logic               cfg_wr;
  logic [0:0]         reg_idx;

  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               s1_start;
  logic               s1_fire;

  hbp_pkg::phase_t    phase;
  logic               hdr_open;

  logic               o_valid;
  hbp_pkg::result_t   o_res;
  logic               p_valid;
  hbp_pkg::result_t   p_res;
  logic               out_pop;

  hbp_pkg::step_in_t  si;
  hbp_pkg::step_out_t so;

  // configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) allow_semi <= 1'b1;
    else if (cfg_wr && reg_idx == hbp_pkg::REG_ALLOW_SEMI) allow_semi <= pwdata[0];
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == hbp_pkg::REG_ALLOW_SEMI) prdata[0] = allow_semi;
  end

  // handshakes: a byte is parsed once the result buffer will be empty
  assign out_pop   = o_valid && outp.ready;
  assign s1_fire   = s1_valid && (!o_valid || (out_pop && !p_valid));
  assign inp.ready = !s1_valid || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (inp.valid && inp.ready) s1_valid <= 1'b1;
    else if (s1_fire) s1_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (inp.valid && inp.ready) begin
      s1_byte  <= inp.data_byte;
      s1_start <= inp.block_start;
    end
  end

  // parse step
  always_comb begin
    si.phase       = phase;
    si.hdr_open    = hdr_open;
    si.data_byte   = s1_byte;
    si.block_start = s1_start;
    si.allow_semi  = allow_semi;
  end

  hbp_step u_step (
    .si (si),
    .so (so)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= hbp_pkg::PH_NAME_START;
      hdr_open <= 1'b0;
    end else if (s1_fire) begin
      phase    <= so.phase_next;
      hdr_open <= so.hdr_open_next;
    end
  end

  // result buffer: head word and one pending word
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      p_valid <= 1'b0;
    end else if (s1_fire) begin
      o_valid <= (so.count != 2'd0);
      p_valid <= (so.count == 2'd2);
    end else if (out_pop) begin
      o_valid <= p_valid;
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_res <= so.res0;
      p_res <= so.res1;
    end else if (out_pop) begin
      o_res <= p_res;
    end
  end

  // result port
  assign outp.valid      = o_valid;
  assign outp.kind       = o_res.kind;
  assign outp.out_byte   = o_res.out_byte;
  assign outp.error_code = o_res.error_code;
  assign outp.last       = o_res.last;

endmodule

// File: rtl/hbp_step.sv
// per-byte parse step: next phase and up to two results for one byte
// depends on hbp_pkg
module hbp_step (
  input  hbp_pkg::step_in_t  si,
  output hbp_pkg::step_out_t so
);

  hbp_pkg::phase_t ph;
  logic            ho;
  logic [7:0]      b;
  logic            tok;
  logic            ws;

  // block start restarts the parse before the byte is handled
  always_comb begin
    ph  = si.block_start ? hbp_pkg::PH_NAME_START : si.phase;
    ho  = si.block_start ? 1'b0 : si.hdr_open;
    b   = si.data_byte;
    tok = hbp_pkg::is_token(si.data_byte);
    ws  = hbp_pkg::is_ws(si.data_byte);
  end

  // next phase and header-open flag
  always_comb begin
    so.phase_next    = ph;
    so.hdr_open_next = ho;
    unique case (ph) inside
      hbp_pkg::PH_NAME_START: begin
        if (b == hbp_pkg::CH_CR) so.phase_next = hbp_pkg::PH_LF_END;
        else if (tok) begin
          so.phase_next    = hbp_pkg::PH_NAME;
          so.hdr_open_next = 1'b1;
        end else so.phase_next = hbp_pkg::PH_ERROR;
      end
      hbp_pkg::PH_NAME: begin
        if (b == hbp_pkg::CH_COLON) so.phase_next = hbp_pkg::PH_VALUE_START;
        else if (ws) so.phase_next = hbp_pkg::PH_COLON;
        else if (!(tok || (b == hbp_pkg::CH_SEMI && si.allow_semi)))
          so.phase_next = hbp_pkg::PH_ERROR;
      end
      hbp_pkg::PH_COLON: begin
        if (b == hbp_pkg::CH_COLON) so.phase_next = hbp_pkg::PH_VALUE_START;
        else if (!ws) so.phase_next = hbp_pkg::PH_ERROR;
      end
      hbp_pkg::PH_VALUE_START, hbp_pkg::PH_VALUE: begin
        if (b == hbp_pkg::CH_CR) so.phase_next = hbp_pkg::PH_LF_VALUE;
        else if (!(ph == hbp_pkg::PH_VALUE_START && ws)) so.phase_next = hbp_pkg::PH_VALUE;
      end
      hbp_pkg::PH_LF_VALUE: begin
        if (b == hbp_pkg::CH_LF) so.phase_next = hbp_pkg::PH_NEXT;
        else so.phase_next = hbp_pkg::PH_ERROR;
      end
      hbp_pkg::PH_NEXT: begin
        if (b == hbp_pkg::CH_CR) begin
          so.phase_next    = hbp_pkg::PH_LF_END;
          so.hdr_open_next = 1'b0;
        end else if (ws) so.phase_next = hbp_pkg::PH_VALUE_START;
        else if (tok) begin
          so.phase_next    = hbp_pkg::PH_NAME;
          so.hdr_open_next = 1'b1;
        end else so.phase_next = hbp_pkg::PH_ERROR;
      end
      hbp_pkg::PH_LF_END: begin
        if (b == hbp_pkg::CH_LF) so.phase_next = hbp_pkg::PH_DONE;
        else so.phase_next = hbp_pkg::PH_ERROR;
      end
      // done, error and unused codes are sticky
      default: ;
    endcase
  end

  // results for this byte
  always_comb begin
    so.count           = 2'd0;
    so.res0.kind       = hbp_pkg::K_NAME;
    so.res0.out_byte   = 8'd0;
    so.res0.error_code = hbp_pkg::ERR_NAME_START;
    so.res0.last       = 1'b1;
    so.res1.kind       = hbp_pkg::K_NAME;
    so.res1.out_byte   = 8'd0;
    so.res1.error_code = hbp_pkg::ERR_NAME_START;
    so.res1.last       = 1'b1;
    unique case (ph) inside
      hbp_pkg::PH_NAME_START: begin
        if (b == hbp_pkg::CH_CR) ;
        else if (tok) begin
          so.count         = 2'd1;
          so.res0.out_byte = b;
        end else begin
          so.count     = 2'd1;
          so.res0.kind = hbp_pkg::K_ERR;
        end
      end
      hbp_pkg::PH_NAME: begin
        if (b == hbp_pkg::CH_COLON || ws) ;
        else if (tok || (b == hbp_pkg::CH_SEMI && si.allow_semi)) begin
          so.count         = 2'd1;
          so.res0.out_byte = b;
        end else begin
          so.count           = 2'd1;
          so.res0.kind       = hbp_pkg::K_ERR;
          so.res0.error_code = hbp_pkg::ERR_NAME_CHAR;
        end
      end
      hbp_pkg::PH_COLON: begin
        if (b != hbp_pkg::CH_COLON && !ws) begin
          so.count           = 2'd1;
          so.res0.kind       = hbp_pkg::K_ERR;
          so.res0.error_code = hbp_pkg::ERR_COLON;
        end
      end
      hbp_pkg::PH_VALUE_START, hbp_pkg::PH_VALUE: begin
        if (b != hbp_pkg::CH_CR && !(ph == hbp_pkg::PH_VALUE_START && ws)) begin
          so.count         = 2'd1;
          so.res0.kind     = hbp_pkg::K_VALUE;
          so.res0.out_byte = b;
        end
      end
      hbp_pkg::PH_LF_VALUE: begin
        if (b != hbp_pkg::CH_LF) begin
          so.count           = 2'd1;
          so.res0.kind       = hbp_pkg::K_ERR;
          so.res0.error_code = hbp_pkg::ERR_LF_VALUE;
        end
      end
      hbp_pkg::PH_NEXT: begin
        so.count = 2'd1;
        if (b == hbp_pkg::CH_CR) so.res0.kind = hbp_pkg::K_HDR;
        else if (ws) begin
          // folded line: one space stands for the line break
          so.res0.kind     = hbp_pkg::K_VALUE;
          so.res0.out_byte = hbp_pkg::CH_SP;
        end else if (tok) begin
          // close the previous header, then the first name byte
          so.count         = 2'd2;
          so.res0.kind     = hbp_pkg::K_HDR;
          so.res0.last     = 1'b0;
          so.res1.out_byte = b;
        end else begin
          so.res0.kind       = hbp_pkg::K_ERR;
          so.res0.error_code = hbp_pkg::ERR_NEXT_HDR;
        end
      end
      hbp_pkg::PH_LF_END: begin
        so.count = 2'd1;
        if (b == hbp_pkg::CH_LF) so.res0.kind = hbp_pkg::K_DONE;
        else begin
          so.res0.kind       = hbp_pkg::K_ERR;
          so.res0.error_code = hbp_pkg::ERR_FINAL_LF;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/hbp_checker.sv
// port-level checks for the header block parser, bound to the top level
// depends on hbp_pkg and http_header_block_parser
module hbp_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input hbp_pkg::kind_t    kind,
  input logic [7:0]        out_byte,
  input hbp_pkg::err_t     error_code,
  input logic              last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
      && $stable(error_code) && $stable(last))
    else $error("result word changed while stalled");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // only name and value results carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != hbp_pkg::K_NAME && kind != hbp_pkg::K_VALUE |-> out_byte == 8'd0)
    else $error("byte set on a marker result");

  // only errors carry a code
  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != hbp_pkg::K_ERR |-> error_code == hbp_pkg::ERR_NAME_START)
    else $error("error code set on a non-error result");

  // done and error always end the results of their byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == hbp_pkg::K_DONE || kind == hbp_pkg::K_ERR) |-> last)
    else $error("done or error result without last");

endmodule

bind http_header_block_parser hbp_checker u_hbp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (outp.valid),
  .out_ready  (outp.ready),
  .kind       (outp.kind),
  .out_byte   (outp.out_byte),
  .error_code (outp.error_code),
  .last       (outp.last)
);
